// ----- design/gaussian_blur_5x5_unit_macros.svh -----
// Assertion helpers for the blur unit; clock and reset are taken from the including scope.
`ifndef GAUSSIAN_BLUR_5X5_UNIT_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_UNIT_MACROS_SVH

// Check a condition at every edge outside reset.
`define GB5_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define GB5_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gb5_pkg.sv -----
`timescale 1ns / 1ps

package gb5_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W  = 8;
   localparam int DIM_W  = 12;
   localparam int ROW_W  = 12;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int KSIZE  = 5;
   localparam int LINES  = KSIZE - 1;
   localparam int LINE_W = LINES * PIX_W;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

   // row sum of the heaviest kernel row times 255 fits in 14 bits, the full sum in 16
   localparam int ROW_SUM_W = 14;
   localparam int SUM_W     = 16;

   // divide by 159: q = (sum * RECIP) >> RECIP_SHIFT, exact for sum below 2^16
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 23;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 16'd52759;
   localparam logic [PIX_W:0] PIX_MAX = 9'd255;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = FIFO_AW + 1;

   localparam int CSR_INDEX_W = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_index_type;

   localparam logic [3:0] KERNEL [KSIZE*KSIZE] = '{
      4'd2, 4'd4,  4'd5,  4'd4,  4'd2,
      4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
      4'd5, 4'd12, 4'd15, 4'd12, 4'd5,
      4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
      4'd2, 4'd4,  4'd5,  4'd4,  4'd2
   };

   // per-item control that follows the window through the pipe
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [KSIZE-1:0] row_ok;
      logic [KSIZE-1:0] col_ok;
   } tap_ctrl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } res_ctrl_type;

endpackage

// ----- design/gaussian_blur_5x5_unit.sv -----
`timescale 1ns / 1ps
`include "gaussian_blur_5x5_unit_macros.svh"
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: gray_value; tuser: is_pad
//  rsp      out  rsp_tvalid/rsp_tready  tdata: blurred_value; tlast: last_of_frame
//  csr      in   csr_valid/csr_ready    csr_index, csr_data
//
//  One pixel word per clock while req_tready is high. A result passes line store read, window
//  shift, row sums, total and divide by 159 between its trigger word and the output buffer.
//  Results queue in an 8-word output buffer; req_tready drops once 8 results are owed.
//  Synchronous reset clears counters, size registers and pipe control; the line store is not
//  cleared, since a tap that reads it inside the image always holds a pixel of the frame.
//  A configuration write to the width or height restarts the frame counters.

module gaussian_blur_5x5_unit
   import gb5_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIX_W-1:0]       req_tdata,   // [7:0] gray_value
   input  logic [0:0]             req_tuser,   // [0] is_pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIX_W-1:0]       rsp_tdata,   // [7:0] blurred_value
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_data
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [DIM_W-1:0] w_eff, h_eff;
   csr_index_type    csr_sel;
   logic             csr_write, csr_hit;

   logic             req_accept;
   logic [PIX_W-1:0] sample;
   logic [ROW_W:0]   cy;
   logic [DIM_W-1:0] cx;
   logic [ROW_W-1:0] cy_u;
   logic             a_emit, a_last;
   tap_ctrl_type     a_ctrl;
   logic [DIM_W-1:0] col_next;

   logic             s1_valid_ff;
   tap_ctrl_type     s1_ctrl_ff;
   logic [PIX_W-1:0] s1_sample_ff;
   logic [COL_W-1:0] s1_col_ff;

   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] mem_rdata_ff;
   logic              byp_ff;
   logic [LINE_W-1:0] byp_data_ff;
   logic [LINE_W-1:0] lines;
   logic [LINE_W-1:0] mem_wdata;
   logic [PIX_W-1:0]  column [KSIZE];

   logic [PIX_W-1:0]     win_ff [KSIZE][KSIZE];
   tap_ctrl_type         s2_ctrl_ff;
   logic [ROW_SUM_W-1:0] row_sum_in [KSIZE];
   logic [ROW_SUM_W-1:0] row_sum_ff [KSIZE];
   res_ctrl_type         s3_ctrl_ff;
   logic [SUM_W-1:0]     sum_in, sum_ff;
   res_ctrl_type         s4_ctrl_ff;
   logic [PROD_W-1:0]    prod;
   logic [PIX_W:0]       quot;
   logic [PIX_W-1:0]     blurred;

   logic [PIX_W:0]   fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fifo_count_ff, outstanding_ff;
   logic             fifo_push, fifo_pop;

   // ---------------------------------------------------------------- config
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;
   assign csr_sel   = csr_index_type'(csr_index);

   always_comb begin
      unique case (csr_sel)
         CSR_IMAGE_WIDTH:  csr_hit = 1'b1;
         CSR_IMAGE_HEIGHT: csr_hit = 1'b1;
         default:          csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0)                       w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH))    w_eff = DIM_W'(MAX_WIDTH);
      else                                      w_eff = width_ff;
      if (height_ff == '0)                      h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT))  h_eff = DIM_W'(MAX_HEIGHT);
      else                                      h_eff = height_ff;
   end

   // ---------------------------------------------------------------- accept stage
   assign req_tready = !reset && (outstanding_ff < CNT_W'(FIFO_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign sample     = req_tuser[0] ? '0 : req_tdata;

   // centre of the output is 2 rows and 2 columns behind the incoming word
   always_comb begin
      if (w_eff == DIM_W'(1)) begin
         cx = '0;
         cy = {1'b0, row_ff} - (ROW_W+1)'(4);
      end else if (col_ff < COL_W'(2)) begin
         cx = DIM_W'(col_ff) + w_eff - DIM_W'(2);
         cy = {1'b0, row_ff} - (ROW_W+1)'(3);
      end else begin
         cx = DIM_W'(col_ff) - DIM_W'(2);
         cy = {1'b0, row_ff} - (ROW_W+1)'(2);
      end
      cy_u   = cy[ROW_W-1:0];
      a_emit = !cy[ROW_W] && (DIM_W'(cy_u) < h_eff);
      a_last = a_emit && (DIM_W'(cy_u) == h_eff - DIM_W'(1)) && (cx == w_eff - DIM_W'(1));
      a_ctrl.valid = a_emit;
      a_ctrl.last  = a_last;
      for (int i = 0; i < KSIZE; i++) begin
         a_ctrl.row_ok[i] = ({1'b0, DIM_W'(cy_u)} + (DIM_W+1)'(i) >= (DIM_W+1)'(2)) &&
                            ({1'b0, DIM_W'(cy_u)} + (DIM_W+1)'(i) <
                             {1'b0, h_eff} + (DIM_W+1)'(2));
         a_ctrl.col_ok[i] = ({1'b0, cx} + (DIM_W+1)'(i) >= (DIM_W+1)'(2)) &&
                            ({1'b0, cx} + (DIM_W+1)'(i) < {1'b0, w_eff} + (DIM_W+1)'(2));
      end
      col_next = DIM_W'(col_ff) + DIM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_write && csr_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (a_last) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_next >= w_eff) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_ctrl_ff  <= '0;
      end else begin
         s1_valid_ff <= req_accept;
         s1_ctrl_ff  <= req_accept ? a_ctrl : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= sample;
         s1_col_ff    <= col_ff;
      end
   end

   // ---------------------------------------------------------------- line store
   // word layout: [7:0] one row back ... [31:24] four rows back
   always_ff @(posedge clock) begin
      if (s1_valid_ff) line_mem[s1_col_ff] <= mem_wdata;
      if (req_accept)  mem_rdata_ff <= line_mem[col_ff];
   end

   // forward a write that lands on the address being read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= req_accept && s1_valid_ff && (s1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= mem_wdata;
   end

   always_comb begin
      lines     = byp_ff ? byp_data_ff : mem_rdata_ff;
      mem_wdata = {lines[LINE_W-PIX_W-1:0], s1_sample_ff};
      column[KSIZE-1] = s1_sample_ff;
      for (int i = 0; i < LINES; i++) begin
         column[LINES-1-i] = lines[i*PIX_W +: PIX_W];
      end
   end

   // ---------------------------------------------------------------- window
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE-1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
            win_ff[i][KSIZE-1] <= column[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
         s4_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= '{valid: s2_ctrl_ff.valid, last: s2_ctrl_ff.last};
         s4_ctrl_ff <= s3_ctrl_ff;
      end
   end

   // ---------------------------------------------------------------- weighted sum
   always_comb begin
      for (int i = 0; i < KSIZE; i++) begin
         row_sum_in[i] = '0;
         for (int j = 0; j < KSIZE; j++) begin
            if (s2_ctrl_ff.row_ok[i] && s2_ctrl_ff.col_ok[j]) begin
               row_sum_in[i] = row_sum_in[i] + ROW_SUM_W'(win_ff[i][j]) *
                               ROW_SUM_W'(KERNEL[i*KSIZE+j]);
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < KSIZE; i++) begin
         sum_in = sum_in + SUM_W'(row_sum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      row_sum_ff <= row_sum_in;
      sum_ff     <= sum_in;
   end

   always_comb begin
      prod    = PROD_W'(sum_ff) * PROD_W'(RECIP);
      quot    = prod[RECIP_SHIFT +: PIX_W+1];
      blurred = (quot > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : quot[PIX_W-1:0];
   end

   // ---------------------------------------------------------------- output buffer
   assign fifo_push  = s4_ctrl_ff.valid;
   assign rsp_tvalid = (fifo_count_ff != '0);
   assign fifo_pop   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = fifo_ff[rd_ptr_ff][PIX_W-1:0];
   assign rsp_tlast  = fifo_ff[rd_ptr_ff][PIX_W];

   always_ff @(posedge clock) begin
      if (fifo_push) fifo_ff[wr_ptr_ff] <= {s4_ctrl_ff.last, blurred};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fifo_count_ff  <= '0;
         outstanding_ff <= '0;
      end else begin
         if (fifo_push) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (fifo_pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         fifo_count_ff  <= fifo_count_ff + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
         // reserve a slot for every accepted word that will yield a result
         outstanding_ff <= outstanding_ff + CNT_W'(req_accept && a_emit) - CNT_W'(fifo_pop);
      end
   end

   // ---------------------------------------------------------------- checks
   `GB5_ASSERT_ALWAYS(a_credit_bound, (outstanding_ff <= CNT_W'(FIFO_DEPTH)) && (fifo_count_ff <= outstanding_ff), "result credit out of bounds")
   `GB5_ASSERT_ALWAYS(a_no_overflow, !fifo_push || fifo_pop || (fifo_count_ff != CNT_W'(FIFO_DEPTH)), "push into full output buffer")
   `GB5_ASSERT_ALWAYS(a_col_in_row, DIM_W'(col_ff) < w_eff, "column counter past row end")
   `GB5_ASSERT_NEXT(a_frame_restart, req_accept && a_last, (col_ff == '0) && (row_ff == '0), "counters not cleared after last output")

endmodule
